@@ design/gcar_pkg.sv @@
// ============================================================================
// Glyph cache package
// Shared constants, controller state type and the command/status structs.
// ============================================================================
`default_nettype none
package gcar_pkg;
  localparam int unsigned CODE_W   = 21;
  localparam int unsigned PAGES_D  = 2;
  localparam int unsigned ROWS_D   = 8;
  localparam int unsigned COLS_D   = 8;
  localparam int unsigned AGE_W_D  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_AGE,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_start;
    logic scan_start;
    logic age_start;
    logic write_slot;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic scan_hit;
    logic age_done;
  } ctrl_sts_t;
endpackage
`default_nettype wire

@@ design/gcar_ram.sv @@
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
`default_nettype none
module gcar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/gcar_datapath.sv @@
// ============================================================================
// Glyph cache datapath
// Slot memories, scan and aging address counters, victim tracking and result.
// ============================================================================
`default_nettype none
module gcar_datapath #(
  parameter int unsigned PAGES   = 2,
  parameter int unsigned ROWS    = 8,
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned AGE_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire logic [gcar_pkg::CODE_W-1:0] char_code,
  input  wire gcar_pkg::ctrl_cmd_t       cmd,
  output gcar_pkg::ctrl_sts_t            sts,
  output logic                           done,
  output logic                           hit,
  output logic                           page_index,
  output logic [2:0]                     slot_row,
  output logic [2:0]                     slot_column,
  output logic                           evicted,
  output logic [gcar_pkg::CODE_W-1:0]    evicted_code
);
  import gcar_pkg::*;

  localparam int unsigned N    = PAGES * ROWS * COLUMNS;
  localparam int unsigned AW   = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW   = $clog2(N + 1);
  localparam int unsigned PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CLW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned POSW = PW + RW + CLW;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  // Memory ports.
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CODE_W-1:0] code_wdata, code_rdata;
  logic [AGE_BITS-1:0] age_wdata, age_rdata;

  gcar_ram #(.WIDTH(CODE_W), .DEPTH(N)) u_code (
    .clk(clk), .we(we), .waddr(waddr), .wdata(code_wdata),
    .raddr(raddr), .rdata(code_rdata));
  gcar_ram #(.WIDTH(AGE_BITS), .DEPTH(N)) u_age (
    .clk(clk), .we(we), .waddr(waddr), .wdata(age_wdata),
    .raddr(raddr), .rdata(age_rdata));

  // Read counter issues addresses; the check index is a registered copy of the read address.
  logic [CW-1:0]       rd_cnt;
  logic [CW-1:0]       chk_cnt;
  logic                chk_valid;
  logic                scanning, aging, clearing;
  logic [CW-1:0]       clr_cnt;
  logic [CODE_W-1:0]   code_q;
  logic                found, free_found;
  logic [AW-1:0]       match_idx, free_idx, best_idx, chosen;
  logic [AGE_BITS-1:0] best_age;
  logic [CODE_W-1:0]   best_code;
  logic [AW-1:0]       chk_idx;
  logic [PW-1:0]       rd_pg;
  logic [RW-1:0]       rd_row;
  logic [CLW-1:0]      rd_col;
  logic [POSW-1:0]     chk_pos;
  logic [POSW-1:0]     match_pos, free_pos, best_pos, chosen_pos;

  assign chk_idx = chk_cnt[AW-1:0];
  assign raddr   = rd_cnt[AW-1:0];

  // Sequencing of the clear, scan and aging sweeps.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      aging     <= 1'b0;
      clearing  <= 1'b0;
      chk_valid <= 1'b0;
      rd_cnt    <= '0;
      chk_cnt   <= '0;
      clr_cnt   <= '0;
      rd_pg     <= '0;
      rd_row    <= '0;
      rd_col    <= '0;
      chk_pos   <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.clear_start) begin
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end else if (clearing) begin
        if (clr_cnt == CW'(N - 1)) begin
          clearing <= 1'b0;
        end
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (cmd.scan_start || cmd.age_start) begin
        scanning  <= cmd.scan_start;
        aging     <= cmd.age_start;
        rd_cnt    <= '0;
        rd_pg     <= '0;
        rd_row    <= '0;
        rd_col    <= '0;
        chk_valid <= 1'b0;
      end else if (scanning || aging) begin
        chk_valid <= (rd_cnt < CW'(N));
        chk_cnt   <= rd_cnt;
        chk_pos   <= {rd_pg, rd_row, rd_col};
        if (rd_cnt < CW'(N)) begin
          rd_cnt <= rd_cnt + CW'(1);
          // Page, row and column of the read address step along with it.
          if (rd_col == CLW'(COLUMNS - 1)) begin
            rd_col <= '0;
            if (rd_row == RW'(ROWS - 1)) begin
              rd_row <= '0;
              rd_pg  <= rd_pg + PW'(1);
            end else begin
              rd_row <= rd_row + RW'(1);
            end
          end else begin
            rd_col <= rd_col + CLW'(1);
          end
        end
        if (sts.scan_done) begin
          scanning <= 1'b0;
        end
        if (sts.age_done) begin
          aging <= 1'b0;
        end
      end
    end
  end

  // Status; the hit flag also covers a match in the last slot checked.
  always_comb begin
    sts            = '0;
    sts.clear_done = clearing && (clr_cnt == CW'(N - 1));
    sts.scan_done  = scanning && chk_valid && (chk_cnt == CW'(N - 1));
    sts.age_done   = aging && chk_valid && (chk_cnt == CW'(N - 1));
    sts.scan_hit   = found || (scanning && chk_valid && age_rdata != '0
                               && code_rdata == code_q);
  end

  // Scan bookkeeping: first match, first free slot, first greatest age.
  always_ff @(posedge clk) begin
    if (load) begin
      code_q     <= char_code;
      found      <= 1'b0;
      free_found <= 1'b0;
      best_age   <= '0;
      best_idx   <= '0;
      best_code  <= '0;
      match_idx  <= '0;
      free_idx   <= '0;
      match_pos  <= '0;
      free_pos   <= '0;
      best_pos   <= '0;
    end else if (scanning && chk_valid) begin
      if (!found && age_rdata != '0 && code_rdata == code_q) begin
        found     <= 1'b1;
        match_idx <= chk_idx;
        match_pos <= chk_pos;
      end
      if (!free_found && age_rdata == '0) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
        free_pos   <= chk_pos;
      end
      if (age_rdata > best_age) begin
        best_age  <= age_rdata;
        best_idx  <= chk_idx;
        best_pos  <= chk_pos;
        best_code <= code_rdata;
      end
    end
  end

  always_comb begin
    priority if (found) begin
      chosen     = match_idx;
      chosen_pos = match_pos;
    end else if (free_found) begin
      chosen     = free_idx;
      chosen_pos = free_pos;
    end else begin
      chosen     = best_idx;
      chosen_pos = best_pos;
    end
  end

  // Memory write selection.
  always_comb begin
    we         = 1'b0;
    waddr      = chosen;
    code_wdata = code_q;
    age_wdata  = AGE_ONE;
    if (clearing) begin
      we         = 1'b1;
      waddr      = clr_cnt[AW-1:0];
      code_wdata = '0;
      age_wdata  = '0;
    end else if (cmd.write_slot) begin
      we = 1'b1;
    end else if (aging && chk_valid && chk_idx != chosen && age_rdata != '0
                 && age_rdata != AGE_MAX) begin
      we         = 1'b1;
      waddr      = chk_idx;
      code_wdata = code_rdata;
      age_wdata  = age_rdata + AGE_ONE;
    end
  end

  // Result register.
  logic [PW-1:0]  ch_pg;
  logic [RW-1:0]  ch_row;
  logic [CLW-1:0] ch_col;
  assign {ch_pg, ch_row, ch_col} = chosen_pos;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit          <= found;
      page_index   <= ch_pg[0];
      slot_row     <= 3'(ch_row);
      slot_column  <= 3'(ch_col);
      evicted      <= !found && !free_found;
      evicted_code <= (!found && !free_found) ? best_code : '0;
    end
  end

`ifndef SYNTHESIS
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !scanning && !aging) else $error("clear overlaps a sweep");
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.write_slot |-> !clearing && !aging)
    else $error("slot write during a sweep");
  a_sweep_excl: assert property (@(posedge clk) disable iff (rst)
    !(scanning && aging)) else $error("scan and aging overlap");
`endif
endmodule
`default_nettype wire

@@ design/gcar_ctrl.sv @@
// ============================================================================
// Glyph cache controller
// Steps one transaction through scan, aging on a miss, slot write and result.
// ============================================================================
`default_nettype none
module gcar_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire gcar_pkg::ctrl_sts_t sts,
  output gcar_pkg::ctrl_cmd_t      cmd,
  output logic                     busy,
  output logic                     load
);
  import gcar_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    busy            = 1'b1;
    load            = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          load           = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          if (sts.scan_hit) begin
            state_next = ST_WRITE;
          end else begin
            cmd.age_start = 1'b1;
            state_next    = ST_AGE;
          end
        end
      end
      ST_AGE: begin
        if (sts.age_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_slot = 1'b1;
        cmd.emit       = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Clear runs once, right after reset.
  logic first;
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else begin
      first <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    load |-> state == ST_IDLE) else $error("load outside idle");
  a_write_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.write_slot |=> state == ST_DONE) else $error("write not followed by done");
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    first |-> state == ST_CLEAR) else $error("clear skipped after reset");
`endif
endmodule
`default_nettype wire

@@ design/glyph_cache_age_replacement.sv @@
// ============================================================================
// Glyph cache with age replacement
// Fully associative cache of glyph slots; one result per character code.
// ============================================================================
//   channel   handshake          payload
//   input     start / busy       char_code
//   result    done (strobe)      hit page_index slot_row slot_column evicted
//                                evicted_code
// A hit scans the N = PAGES*ROWS*COLUMNS slots (128 by default) once; a miss
// also runs the aging sweep. Each sweep reads the slot RAM port one slot per cycle.
// After reset a clearing pass over all N slots holds busy high.
// The result strobe is one cycle wide; the receiver cannot stall.
`default_nettype none
module glyph_cache_age_replacement #(
  parameter int unsigned PAGES    = gcar_pkg::PAGES_D,
  parameter int unsigned ROWS     = gcar_pkg::ROWS_D,
  parameter int unsigned COLUMNS  = gcar_pkg::COLS_D,
  parameter int unsigned AGE_BITS = gcar_pkg::AGE_W_D
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [gcar_pkg::CODE_W-1:0] char_code,
  output logic                             done,
  output logic                             hit,
  output logic                             page_index,
  output logic [2:0]                       slot_row,
  output logic [2:0]                       slot_column,
  output logic                             evicted,
  output logic [gcar_pkg::CODE_W-1:0]      evicted_code
);
  import gcar_pkg::*;

  ctrl_cmd_t cmd, cmd_i;
  ctrl_sts_t sts;
  logic      load;
  logic      rst_q;

  // Clear sweep is launched on the cycle after reset.
  always_ff @(posedge clk) begin
    rst_q <= rst;
  end
  always_comb begin
    cmd_i             = cmd;
    cmd_i.clear_start = rst_q && !rst;
  end

  gcar_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .load(load));

  gcar_datapath #(.PAGES(PAGES), .ROWS(ROWS), .COLUMNS(COLUMNS),
    .AGE_BITS(AGE_BITS)) u_dp (
    .clk(clk), .rst(rst), .load(load), .char_code(char_code), .cmd(cmd_i),
    .sts(sts), .done(done), .hit(hit), .page_index(page_index),
    .slot_row(slot_row), .slot_column(slot_column), .evicted(evicted),
    .evicted_code(evicted_code));

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a transaction");
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted) else $error("eviction reported on a hit");
  a_no_code_clean: assert property (@(posedge clk) disable iff (rst)
    done && !evicted |-> evicted_code == '0) else $error("stray evicted code");
`endif
endmodule
`default_nettype wire
